// File: hw/rtl/usart_rx_fifo_register_block_unit_macros.svh
// assertion helpers for the checker of this block
`ifndef USART_RX_FIFO_REGISTER_BLOCK_UNIT_MACROS_SVH
`define USART_RX_FIFO_REGISTER_BLOCK_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define UFRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ufrb assertion failed");

// next-cycle implication, disabled while in reset
`define UFRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ufrb assertion failed");

`endif

// File: hw/rtl/ufrb_pkg.sv
// ----------------------------------------------------------------------------
// ufrb_pkg
// types, register map and sizing shared by the uart register block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufrb_pkg;

	// receive fifo sizing
	localparam int FIFO_DEPTH = 256;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W      = CNT_W + 1;

	// item kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_RX    = 2'd2;

	// word indexes of the register map
	localparam logic [3:0] REG_CTRL = 4'd0;
	localparam logic [3:0] REG_REQ  = 4'd6;
	localparam logic [3:0] REG_STAT = 4'd7;
	localparam logic [3:0] REG_CLR  = 4'd8;
	localparam logic [3:0] REG_RXD  = 4'd9;
	localparam logic [3:0] REG_TXD  = 4'd10;

	// control word bits
	localparam int CTRL_UE     = 0;
	localparam int CTRL_RE     = 2;
	localparam int CTRL_TE     = 3;
	localparam int CTRL_RXNEIE = 5;
	localparam int CTRL_TCIE   = 6;
	localparam int CTRL_TXEIE  = 7;

	// status word bits
	localparam int STAT_RXNE  = 5;
	localparam int STAT_TC    = 6;
	localparam int STAT_TXE   = 7;
	localparam int STAT_TEACK = 21;
	localparam int STAT_REACK = 22;

	// request word flush bit
	localparam int REQ_FLUSH = 3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} req_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        rx_dropped;
	} rsp_item_t;

	// fifo commands from the decoder
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       flush;
		logic [7:0] push_byte;
	} fifo_ctl_t;

	// fifo fill status
	typedef struct packed {
		logic nonempty;
		logic full;
	} fifo_stat_t;

	// register file write port
	typedef struct packed {
		logic        en;
		logic [3:0]  idx;
		logic [31:0] data;
	} reg_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/ufrb_fifo.sv
// ----------------------------------------------------------------------------
// ufrb_fifo
// receive byte fifo with registered read port and flush
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufrb_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ufrb_pkg::fifo_ctl_t ctl,
	output ufrb_pkg::fifo_stat_t     stat,
	output logic [7:0]               rd_byte
);

	logic [7:0]                   mem [ufrb_pkg::FIFO_DEPTH];
	logic [ufrb_pkg::PTR_W-1:0]   head_q;
	logic [ufrb_pkg::CNT_W-1:0]   fill_q;
	logic [ufrb_pkg::SUM_W-1:0]   tail_sum;
	logic [ufrb_pkg::PTR_W-1:0]   tail;
	logic [ufrb_pkg::PTR_W-1:0]   head_inc;
	logic [7:0]                   rd_byte_q;

	assign stat.nonempty = (fill_q != '0);
	assign stat.full     = (fill_q == ufrb_pkg::CNT_W'(ufrb_pkg::FIFO_DEPTH));

	// write position, wrapped once
	always_comb begin
		tail_sum = ufrb_pkg::SUM_W'(head_q) + ufrb_pkg::SUM_W'(fill_q);
		if (tail_sum >= ufrb_pkg::SUM_W'(ufrb_pkg::FIFO_DEPTH)) begin
			tail_sum = tail_sum - ufrb_pkg::SUM_W'(ufrb_pkg::FIFO_DEPTH);
		end
		tail = tail_sum[ufrb_pkg::PTR_W-1:0];
	end

	assign head_inc = (head_q == ufrb_pkg::PTR_W'(ufrb_pkg::FIFO_DEPTH - 1)) ?
		'0 : head_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctl.flush) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctl.pop) begin
			head_q <= head_inc;
			fill_q <= fill_q - 1'b1;
		end else if (ctl.push) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail] <= ctl.push_byte;
		end
		if (ctl.pop) begin
			rd_byte_q <= mem[head_q];
		end
	end

	assign rd_byte = rd_byte_q;

endmodule

`default_nettype wire

// File: hw/rtl/ufrb_regs.sv
// ----------------------------------------------------------------------------
// ufrb_regs
// register file, computed status word and interrupt level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufrb_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ufrb_pkg::reg_wr_t wr,
	input  wire logic [3:0]        rd_idx,
	input  wire logic              fifo_nonempty,
	output logic [31:0]            rd_word,
	output logic                   irq
);

	logic [31:0] rf_q [16];
	logic [31:0] ctrl;
	logic [31:0] status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				rf_q[i] <= '0;
			end
		end else if (wr.en) begin
			rf_q[wr.idx] <= wr.data;
		end
	end

	assign ctrl = rf_q[ufrb_pkg::REG_CTRL];

	always_comb begin
		status                       = '0;
		status[ufrb_pkg::STAT_TXE]   = 1'b1;
		status[ufrb_pkg::STAT_TC]    = 1'b1;
		status[ufrb_pkg::STAT_RXNE]  = fifo_nonempty;
		status[ufrb_pkg::STAT_TEACK] = ctrl[ufrb_pkg::CTRL_UE] & ctrl[ufrb_pkg::CTRL_TE];
		status[ufrb_pkg::STAT_REACK] = ctrl[ufrb_pkg::CTRL_UE] & ctrl[ufrb_pkg::CTRL_RE];
	end

	assign rd_word = (rd_idx == ufrb_pkg::REG_STAT) ? status : rf_q[rd_idx];

	assign irq = (ctrl[ufrb_pkg::CTRL_RXNEIE] & fifo_nonempty)
		| ctrl[ufrb_pkg::CTRL_TCIE] | ctrl[ufrb_pkg::CTRL_TXEIE];

endmodule

`default_nettype wire

// File: hw/rtl/usart_rx_fifo_register_block_unit.sv
// ----------------------------------------------------------------------------
// usart_rx_fifo_register_block_unit
// uart register block with receive fifo, one bus access or serial byte per item
// ----------------------------------------------------------------------------
// The block takes one item per clock while req_stall is low: a bus read, a bus
// write or one byte from the serial line, and returns exactly one result item
// for each. An item is first held in the input register, then it is decoded,
// applied to the register file and the receive fifo, and lands in the result
// register. Throughput is one item per cycle while the result side keeps up;
// the pace is set by the result side, and the read data of the fifo memory is
// registered together with the result. The fifo memory needs no clearing
// after reset; the block accepts items right after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module usart_rx_fifo_register_block_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire ufrb_pkg::req_item_t req_item,
	// response channel
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output ufrb_pkg::rsp_item_t      rsp_item
);

	// stage 1: captured item
	logic                valid_s1;
	ufrb_pkg::req_item_t item_s1;

	// stage 2: result
	logic                valid_s2;
	logic                pop_s2;
	logic [31:0]         word_s2;
	logic                tx_valid_s2;
	logic [7:0]          tx_byte_s2;
	logic                drop_s2;

	logic                move_s2;
	logic                is_read;
	logic                is_write;
	logic                is_rx;
	logic                idx_rxd;
	logic                idx_store;

	ufrb_pkg::fifo_ctl_t  fifo_ctl;
	ufrb_pkg::fifo_stat_t fifo_stat;
	ufrb_pkg::reg_wr_t    reg_wr;
	logic [7:0]           fifo_rd_byte;
	logic [31:0]          rd_word;
	logic                 irq;

	// item moves from the input register into the result register
	assign move_s2   = valid_s1 & (~valid_s2 | ~rsp_stall);
	assign req_stall = valid_s1 & ~move_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (move_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_item;
		end
	end

	// decode of the captured item
	assign is_read  = (item_s1.kind == ufrb_pkg::KIND_READ);
	assign is_write = (item_s1.kind == ufrb_pkg::KIND_WRITE);
	assign is_rx    = (item_s1.kind == ufrb_pkg::KIND_RX);
	assign idx_rxd  = (item_s1.reg_index == ufrb_pkg::REG_RXD);

	// request, status, clear, receive and transmit words keep nothing
	assign idx_store = (item_s1.reg_index != ufrb_pkg::REG_REQ)
		&& (item_s1.reg_index != ufrb_pkg::REG_STAT)
		&& (item_s1.reg_index != ufrb_pkg::REG_CLR)
		&& (item_s1.reg_index != ufrb_pkg::REG_RXD)
		&& (item_s1.reg_index != ufrb_pkg::REG_TXD);

	// fifo commands, only when the item really moves on
	always_comb begin
		fifo_ctl.pop       = move_s2 & is_read & idx_rxd & fifo_stat.nonempty;
		fifo_ctl.push      = move_s2 & is_rx & ~fifo_stat.full;
		fifo_ctl.flush     = move_s2 & is_write
			& (item_s1.reg_index == ufrb_pkg::REG_REQ)
			& item_s1.write_data[ufrb_pkg::REQ_FLUSH];
		fifo_ctl.push_byte = item_s1.rx_byte;
	end

	always_comb begin
		reg_wr.en   = move_s2 & is_write & idx_store;
		reg_wr.idx  = item_s1.reg_index;
		reg_wr.data = item_s1.write_data;
	end

	ufrb_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fifo_ctl),
		.stat    (fifo_stat),
		.rd_byte (fifo_rd_byte)
	);

	ufrb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr            (reg_wr),
		.rd_idx        (item_s1.reg_index),
		.fifo_nonempty (fifo_stat.nonempty),
		.rd_word       (rd_word),
		.irq           (irq)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s2) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			pop_s2      <= fifo_ctl.pop;
			// plain register read; the receive word gets its byte from the fifo
			word_s2     <= (is_read && !idx_rxd) ? rd_word : '0;
			tx_valid_s2 <= is_write & (item_s1.reg_index == ufrb_pkg::REG_TXD);
			tx_byte_s2  <= (is_write && (item_s1.reg_index == ufrb_pkg::REG_TXD)) ?
				item_s1.write_data[7:0] : '0;
			drop_s2     <= is_rx & fifo_stat.full;
		end
	end

	// block state only changes when a result is loaded, so the interrupt
	// level seen now is the one left by the item in the result register
	always_comb begin
		rsp_item.read_data  = pop_s2 ? {24'd0, fifo_rd_byte} : word_s2;
		rsp_item.irq_level  = irq;
		rsp_item.tx_valid   = tx_valid_s2;
		rsp_item.tx_byte    = tx_byte_s2;
		rsp_item.rx_dropped = drop_s2;
	end

	assign rsp_valid = valid_s2;

endmodule

`default_nettype wire

// File: hw/rtl/ufrb_checker.sv
// ----------------------------------------------------------------------------
// ufrb_checker
// port level checks of the uart register block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "usart_rx_fifo_register_block_unit_macros.svh"

module ufrb_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_stall,
	input wire logic                rsp_valid,
	input wire logic                rsp_stall,
	input wire ufrb_pkg::rsp_item_t rsp_item
);

	logic rsp_held;
	logic tx_quiet;
	logic rdata_nz;

	assign rsp_held = rsp_valid && rsp_stall;
	assign tx_quiet = rsp_valid && !rsp_item.tx_valid;
	assign rdata_nz = rsp_valid && (rsp_item.read_data != 32'd0);

	// a held result does not change
	`UFRB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_held, rsp_valid && $stable(rsp_item))

	// input only backs up behind a held result
	`UFRB_ASSERT_IMPL(a_stall_held_result, clk, arst_n, req_stall, rsp_held)

	// no byte shows without a transmit
	`UFRB_ASSERT_IMPL(a_tx_byte_idle, clk, arst_n, tx_quiet, rsp_item.tx_byte == 8'd0)

	// read data only comes from reads
	`UFRB_ASSERT_IMPL(a_rdata_read_only, clk, arst_n, rdata_nz, !rsp_item.tx_valid && !rsp_item.rx_dropped)

endmodule

bind usart_rx_fifo_register_block_unit ufrb_checker u_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// item-level checks of the uart register block with receive fifo
// ----------------------------------------------------------------------------
// A shadow copy of the register file and the receive fifo predicts every
// result item. Directed items cover the register map, the transmit word, the
// flush request and the empty fifo read. A fill past full runs under a long
// receiver hold-off and also wraps the fifo pointers. Random traffic then
// runs under three idling mixes on both channels.
`timescale 1ns / 1ps

module tb_top;
	import ufrb_pkg::*;

	// the block has no name for the fourth kind, which is an idle item
	localparam logic [1:0] KIND_IDLE = 2'd3;

	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int REPORT_LIMIT   = 10;
	localparam int RANDOM_PER_MIX = 68;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_item = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;

	usart_rx_fifo_register_block_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow state of the block
	logic [31:0]      shadow_regs [16];
	logic [7:0]       shadow_fifo [FIFO_DEPTH];
	logic [PTR_W-1:0] shadow_head;
	logic [CNT_W-1:0] shadow_fill;

	rsp_item_t expected_rsp_q [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int results_checked = 0;
	int dropped_bytes = 0;
	int mismatches = 0;

	// status word as the block would present it right now
	function automatic logic [31:0] status_word();
		logic [31:0] st;
		logic [31:0] ctl;
		ctl = shadow_regs[REG_CTRL];
		st = '0;
		st[STAT_TXE]   = 1'b1;
		st[STAT_TC]    = 1'b1;
		st[STAT_RXNE]  = (shadow_fill != 0);
		st[STAT_TEACK] = ctl[CTRL_UE] & ctl[CTRL_TE];
		st[STAT_REACK] = ctl[CTRL_UE] & ctl[CTRL_RE];
		return st;
	endfunction

	// applies one item to the shadow state and returns the result it causes
	function automatic rsp_item_t predict_response(req_item_t it);
		rsp_item_t r;
		logic [31:0] ctl;
		int tail;
		r = '0;
		case (it.kind)
			KIND_READ: begin
				if (it.reg_index == REG_RXD) begin
					// popping an empty fifo returns zero and changes nothing
					if (shadow_fill != 0) begin
						r.read_data = {24'd0, shadow_fifo[shadow_head]};
						shadow_head = (int'(shadow_head) + 1 >= FIFO_DEPTH) ?
							'0 : shadow_head + 1'b1;
						shadow_fill = shadow_fill - 1'b1;
					end
				end else if (it.reg_index == REG_STAT) begin
					r.read_data = status_word();
				end else begin
					r.read_data = shadow_regs[it.reg_index];
				end
			end
			KIND_WRITE: begin
				if (it.reg_index == REG_TXD) begin
					r.tx_valid = 1'b1;
					r.tx_byte  = it.write_data[7:0];
				end else if (it.reg_index == REG_REQ) begin
					if (it.write_data[REQ_FLUSH]) begin
						shadow_head = '0;
						shadow_fill = '0;
					end
				end else if (it.reg_index != REG_CLR && it.reg_index != REG_STAT &&
						it.reg_index != REG_RXD) begin
					shadow_regs[it.reg_index] = it.write_data;
				end
			end
			KIND_RX: begin
				if (shadow_fill >= FIFO_DEPTH) begin
					r.rx_dropped = 1'b1;
				end else begin
					tail = int'(shadow_head) + int'(shadow_fill);
					if (tail >= FIFO_DEPTH)
						tail -= FIFO_DEPTH;
					shadow_fifo[tail] = it.rx_byte;
					shadow_fill = shadow_fill + 1'b1;
				end
			end
			default: ;
		endcase
		ctl = shadow_regs[REG_CTRL];
		r.irq_level = (ctl[CTRL_RXNEIE] && shadow_fill != 0) || ctl[CTRL_TCIE] ||
			ctl[CTRL_TXEIE];
		return r;
	endfunction

	// receiver: random stall, or a counted hold-off when the token moves
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch in result %0d, %s: expected %h, got %h",
					results_checked, name, want, got);
		end
	endtask

	// every accepted result against the oldest expectation
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result %h arrived with no item pending", rsp_item);
			end else begin
				want = expected_rsp_q.pop_front();
				check_field("read_data", want.read_data, rsp_item.read_data);
				check_field("irq_level", 32'(want.irq_level), 32'(rsp_item.irq_level));
				check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_item.tx_valid));
				check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_item.tx_byte));
				check_field("rx_dropped", 32'(want.rx_dropped), 32'(rsp_item.rx_dropped));
				if (want.rx_dropped)
					dropped_bytes++;
			end
			results_checked++;
		end
	end

	// watchdog on cycles where neither channel moves an item
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("tb_top: errors");
			$finish;
		end
	end

	// offers one item, with random gaps before it, and records its result
	task automatic send_item(input req_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_rsp_q.push_back(predict_response(it));
		items_sent++;
	endtask

	// all fields random, so unused fields toggle too
	function automatic req_item_t noise_item();
		req_item_t it;
		it.kind       = 2'($urandom_range(0, 3));
		it.reg_index  = 4'($urandom_range(0, 15));
		it.write_data = $urandom();
		it.rx_byte    = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic bus_read(input logic [3:0] idx);
		req_item_t it;
		it = noise_item();
		it.kind = KIND_READ;
		it.reg_index = idx;
		send_item(it);
	endtask

	task automatic bus_write(input logic [3:0] idx, input logic [31:0] data);
		req_item_t it;
		it = noise_item();
		it.kind = KIND_WRITE;
		it.reg_index = idx;
		it.write_data = data;
		send_item(it);
	endtask

	task automatic serial_byte(input logic [7:0] b);
		req_item_t it;
		it = noise_item();
		it.kind = KIND_RX;
		it.rx_byte = b;
		send_item(it);
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct <= receiver_pct;
	endtask

	// reset values, storing words, ignored words, enable acks
	task automatic test_register_map();
		bus_read(REG_STAT);
		bus_read(4'd3);
		bus_write(REG_CTRL, 32'hFFFF_FFFF);
		bus_read(REG_STAT);
		bus_write(REG_CTRL, 32'h0000_0000);
		bus_write(4'd15, 32'hFFFF_FFFF);
		bus_read(4'd15);
		bus_write(4'd1, 32'h0000_0000);
		bus_write(REG_STAT, 32'hFFFF_FFFF);
		bus_write(REG_CLR, 32'hFFFF_FFFF);
		bus_write(REG_RXD, 32'hFFFF_FFFF);
		bus_read(REG_STAT);
		bus_read(REG_CLR);
	endtask

	// transmit word emits its low byte and never stores
	task automatic test_transmit_word();
		bus_write(REG_TXD, 32'hFFFF_FFFF);
		bus_write(REG_TXD, 32'h0000_0000);
		bus_read(REG_TXD);
	endtask

	// empty pop, flush bit clear and set, idle item
	task automatic test_fifo_basics();
		req_item_t it;
		bus_read(REG_RXD);
		serial_byte(8'hFF);
		serial_byte(8'h00);
		bus_read(REG_STAT);
		bus_write(REG_REQ, ~(32'd1 << REQ_FLUSH));
		bus_read(REG_REQ);
		bus_read(REG_RXD);
		bus_write(REG_REQ, 32'd1 << REQ_FLUSH);
		bus_read(REG_RXD);
		bus_write(REG_CTRL, 32'd1 << CTRL_TXEIE);
		it = noise_item();
		it.kind = KIND_IDLE;
		send_item(it);
	endtask

	// fill past full under a long hold-off, then wrap both pointers
	task automatic test_fifo_overflow();
		bus_write(REG_REQ, 32'd1 << REQ_FLUSH);
		bus_write(REG_CTRL, ($urandom() & ~32'h0000_00C0) | (32'd1 << CTRL_RXNEIE));
		hold_token <= hold_token + 1;
		repeat (FIFO_DEPTH + 2)
			serial_byte(8'($urandom_range(0, 255)));
		repeat (FIFO_DEPTH - 6)
			bus_read(REG_RXD);
		repeat (50)
			serial_byte(8'($urandom_range(0, 255)));
		repeat (60)
			bus_read(REG_RXD);
	endtask

	// mixed traffic, biased toward the fifo and the special words
	task automatic test_random_traffic(input int count);
		req_item_t it;
		int pick;
		repeat (count) begin
			it = noise_item();
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				it.kind = KIND_RX;
			end else if (pick < 65) begin
				it.kind = KIND_READ;
				if ($urandom_range(0, 1))
					it.reg_index = REG_RXD;
			end else if (pick < 95) begin
				it.kind = KIND_WRITE;
				case ($urandom_range(0, 3))
					0: it.reg_index = REG_CTRL;
					1: begin
						it.reg_index = REG_REQ;
						it.write_data[REQ_FLUSH] = ($urandom_range(0, 9) == 0);
					end
					2: it.reg_index = REG_TXD;
					default: ;
				endcase
			end else begin
				it.kind = KIND_IDLE;
			end
			send_item(it);
		end
	endtask

	initial begin
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;
		foreach (shadow_fifo[i])
			shadow_fifo[i] = '0;
		shadow_head = '0;
		shadow_fill = '0;

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		set_idling(23, 57);
		test_register_map();
		test_transmit_word();
		test_fifo_basics();
		test_fifo_overflow();
		test_random_traffic(RANDOM_PER_MIX);
		set_idling(57, 23);
		test_random_traffic(RANDOM_PER_MIX);
		set_idling(0, 0);
		test_random_traffic(RANDOM_PER_MIX);
		req_valid <= 1'b0;

		// the watchdog catches results that never come
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("summary: %0d items of all four kinds sent, fifo filled past full and wrapped",
			items_sent);
		$display("summary: %0d results checked, %0d bytes dropped, %0d mismatches, %0d left",
			results_checked, dropped_bytes, mismatches, expected_rsp_q.size());
		if (mismatches == 0 && expected_rsp_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
